@@ design/edid_base_block_field_extractor_macros.svh @@
// Assertion helpers for the EDID extractor.
`ifndef EDID_BASE_BLOCK_FIELD_EXTRACTOR_MACROS_SVH
`define EDID_BASE_BLOCK_FIELD_EXTRACTOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EBX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define EBX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/edid_pkg.sv @@
package edid_pkg;

  localparam int TextChars  = 13;
  localparam int DescCount  = 4;
  localparam int DescStart  = 54;
  localparam int DescSize   = 18;
  localparam int DescData   = 13;
  localparam int HdrFirst   = 8;
  localparam int HdrBytes   = 27;
  localparam int LastPos    = 127;
  localparam int ExtPos     = 126;
  localparam int StoreDepth = 3 * DescData;
  localparam int YearBase   = 1990;

  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] TAG_NAME  = 8'hfc;
  localparam logic [7:0] TAG_SER   = 8'hff;
  localparam logic [7:0] TAG_OTHER = 8'hfe;
  localparam logic [7:0] WEEK_MY   = 8'hff;

  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_NAME  = 2'd1;
  localparam logic [1:0] TGT_SER   = 2'd2;
  localparam logic [1:0] TGT_OTHER = 2'd3;

  localparam logic [3:0] KIND_ID     = 4'd0;
  localparam logic [3:0] KIND_SERIAL = 4'd1;
  localparam logic [3:0] KIND_DATES  = 4'd2;
  localparam logic [3:0] KIND_MISC   = 4'd3;
  localparam logic [3:0] KIND_RG     = 4'd4;
  localparam logic [3:0] KIND_BW     = 4'd5;
  localparam logic [3:0] KIND_NAME   = 4'd6;

  typedef logic [5:0] store_addr_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // string s (0..2) occupies DescData entries starting here
  function automatic store_addr_t store_base(input logic [1:0] s);
    store_addr_t r;
    case (s)
      2'd0:    r = store_addr_t'(0);
      2'd1:    r = store_addr_t'(DescData);
      2'd2:    r = store_addr_t'(2 * DescData);
      default: r = store_addr_t'(0);
    endcase
    return r;
  endfunction

endpackage

@@ design/edid_in_if.sv @@
interface edid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

@@ design/edid_out_if.sv @@
interface edid_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [3:0]  char_slot;
  logic [39:0] record_value;
  logic        is_last;

  modport source (output valid, output record_kind, output char_slot, output record_value,
                  output is_last, input ready);
  modport sink (input valid, input record_kind, input char_slot, input record_value,
                input is_last, output ready);
endinterface

@@ design/edid_base_block_field_extractor.sv @@
// Bytes 0..126 are accepted in the input state; a byte that closes a text descriptor starts
//   a scan of the string memory that drops trailing blanks, one character per S_TRIM/S_TWAIT
//   pass, and clears the string if it trims to empty; input stalls during the scan.
// Byte 127 starts emission: 6 records at one per cycle when the output is not stalled, then one
//   record per text character (one memory read each); input stalls until the last record is loaded.
// Reset (synchronous, rst high) clears position, checksum, descriptor state and lengths;
//   header bytes and the string memory are not cleared.
`include "edid_base_block_field_extractor_macros.svh"

module edid_base_block_field_extractor (
  input logic clk,
  input logic rst,
  edid_in_if.sink byte_in,
  edid_out_if.source rec_out
);
  import edid_pkg::*;

  typedef enum logic [5:0] {
    S_IN    = 6'b000001,
    S_TRIM  = 6'b000010,
    S_TWAIT = 6'b000100,
    S_REC   = 6'b001000,
    S_CRD   = 6'b010000,
    S_CWT   = 6'b100000
  } state_t;

  state_t       state;
  logic [6:0]   pos;
  logic [7:0]   sum;
  logic [7:0]   hdr [HdrBytes];
  logic [7:0]   ext;
  logic [4:0]   off;
  logic         qual;
  logic [1:0]   tgt;
  logic         stopped;
  logic [3:0]   len [3];
  logic [3:0]   trim_n;
  logic [2:0]   rec_idx;
  logic [1:0]   s_ptr;
  logic [3:0]   i_ptr;
  logic [7:0]   store [StoreDepth];
  store_addr_t  rd_addr;
  logic [7:0]   rd_data;

  logic         out_valid;
  logic [3:0]   out_kind;
  logic [3:0]   out_slot;
  logic [39:0]  out_value;
  logic         out_last;

  logic         accept, out_free, out_load, in_desc, wr_en;
  logic [7:0]   b;
  logic [1:0]   tgt_m1;
  logic [3:0]   idx;
  store_addr_t  wr_addr;
  logic [39:0]  rec_val;
  logic [3:0]   rec_kind;
  logic [2:0]   first0, after_cur;
  logic [11:0]  year;

  function automatic logic [2:0] first_nonempty(input logic [1:0] start,
                                                input logic [3:0] l0, input logic [3:0] l1,
                                                input logic [3:0] l2);
    logic [2:0] r;
    r = 3'b000;
    if (start <= 2'd2 && l2 != 4'd0) r = {1'b1, 2'd2};
    if (start <= 2'd1 && l1 != 4'd0) r = {1'b1, 2'd1};
    if (start == 2'd0 && l0 != 4'd0) r = {1'b1, 2'd0};
    return r;
  endfunction

  assign b        = byte_in.byte_value;
  assign byte_in.ready = (state == S_IN);
  assign accept   = byte_in.valid && byte_in.ready;
  assign out_free = !out_valid || rec_out.ready;
  assign out_load = out_free && (state == S_REC || state == S_CWT);
  assign in_desc  = (pos >= 7'(DescStart)) && (pos < 7'(DescStart + DescSize * DescCount));
  assign tgt_m1   = tgt - 2'd1;
  assign idx      = 4'(off - 5'd5);
  assign wr_en    = accept && in_desc && (off >= 5'd5) && (tgt != TGT_NONE) && !stopped
                    && (idx < 4'(TextChars)) && (b != CHAR_LF) && (b != 8'h00);
  assign wr_addr  = store_base(tgt_m1) + store_addr_t'(idx);

  assign first0    = first_nonempty(2'd0, len[0], len[1], len[2]);
  assign after_cur = (s_ptr == 2'd2) ? 3'b000
                     : first_nonempty(s_ptr + 2'd1, len[0], len[1], len[2]);

  always_comb begin
    if (state == S_TRIM) rd_addr = store_base(tgt_m1) + store_addr_t'(trim_n - 4'd1);
    else rd_addr = store_base(s_ptr) + store_addr_t'(i_ptr);
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= b;
    rd_data <= store[rd_addr];
  end

  assign year = 12'(hdr[9]) + 12'(YearBase);

  always_comb begin
    rec_val  = '0;
    rec_kind = KIND_ID;
    case (rec_idx)
      3'd0: begin
        rec_kind = KIND_ID;
        rec_val = {3'b010, hdr[0][6:2], 3'b010, hdr[0][1:0], hdr[1][7:5],
                   3'b010, hdr[1][4:0], hdr[3], hdr[2]};
      end
      3'd1: begin
        rec_kind = KIND_SERIAL;
        rec_val = {8'd0, hdr[7], hdr[6], hdr[5], hdr[4]};
      end
      3'd2: begin
        rec_kind = KIND_DATES;
        rec_val = {year, hdr[8] == WEEK_MY, 3'b000, hdr[8], hdr[10], hdr[11]};
      end
      3'd3: begin
        rec_kind = KIND_MISC;
        rec_val = {hdr[12], hdr[16], ext, 3'b000, sum == 8'd0, len[0], len[1], len[2]};
      end
      3'd4: begin
        rec_kind = KIND_RG;
        rec_val = {hdr[19], hdr[17][7:6], hdr[20], hdr[17][5:4],
                   hdr[21], hdr[17][3:2], hdr[22], hdr[17][1:0]};
      end
      3'd5: begin
        rec_kind = KIND_BW;
        rec_val = {hdr[23], hdr[18][7:6], hdr[24], hdr[18][5:4],
                   hdr[25], hdr[18][3:2], hdr[26], hdr[18][1:0]};
      end
      default: begin
        rec_kind = KIND_ID;
        rec_val = '0;
      end
    endcase
  end

  // header bytes: payload only
  always_ff @(posedge clk) begin
    if (accept && pos >= 7'(HdrFirst) && pos < 7'(HdrFirst + HdrBytes))
      hdr[5'(pos - 7'(HdrFirst))] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      pos       <= '0;
      sum       <= '0;
      ext       <= '0;
      off       <= '0;
      qual      <= 1'b0;
      tgt       <= TGT_NONE;
      stopped   <= 1'b0;
      len       <= '{default: 4'd0};
      trim_n    <= '0;
      rec_idx   <= '0;
      s_ptr     <= '0;
      i_ptr     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (rec_out.ready) out_valid <= 1'b0;
      case (state)
        S_IN: begin
          if (accept) begin
            sum <= sum + b;
            pos <= pos + 7'd1;
            if (pos == 7'(ExtPos)) ext <= b;
            if (in_desc) begin
              off <= (off == 5'(DescSize - 1)) ? 5'd0 : off + 5'd1;
              case (off)
                5'd0: begin
                  qual    <= (b == 8'h00);
                  tgt     <= TGT_NONE;
                  stopped <= 1'b0;
                end
                5'd1, 5'd2: qual <= qual && (b == 8'h00);
                5'd3: begin
                  if (b == TAG_NAME) tgt <= TGT_NAME;
                  else if (b == TAG_SER) tgt <= TGT_SER;
                  else if (b == TAG_OTHER) tgt <= TGT_OTHER;
                  else tgt <= TGT_NONE;
                end
                5'd4: begin
                  if (qual && b == 8'h00 && tgt != TGT_NONE) begin
                    len[tgt_m1] <= 4'd0;
                    stopped     <= 1'b0;
                  end else begin
                    tgt <= TGT_NONE;
                  end
                end
                default: begin
                  if (tgt != TGT_NONE) begin
                    if (!stopped && idx < 4'(TextChars) && (b == CHAR_LF || b == 8'h00))
                      stopped <= 1'b1;
                    if (wr_en) len[tgt_m1] <= idx + 4'd1;
                    if (off == 5'(DescSize - 1)) begin
                      trim_n <= wr_en ? idx + 4'd1 : len[tgt_m1];
                      state  <= S_TRIM;
                    end
                  end
                end
              endcase
            end
            if (pos == 7'(LastPos)) begin
              rec_idx <= '0;
              state   <= S_REC;
            end
          end
        end
        S_TRIM: begin
          if (trim_n == 4'd0) begin
            len[tgt_m1] <= 4'd0;
            tgt         <= TGT_NONE;
            state       <= S_IN;
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          if (is_blank(rd_data)) begin
            trim_n <= trim_n - 4'd1;
            state  <= S_TRIM;
          end else begin
            len[tgt_m1] <= trim_n;
            tgt         <= TGT_NONE;
            state       <= S_IN;
          end
        end
        S_REC: begin
          if (out_free) begin
            out_kind  <= rec_kind;
            out_slot  <= 4'd0;
            out_value <= rec_val;
            out_last  <= (rec_idx == 3'd5) && !first0[2];
            if (rec_idx == 3'd5) begin
              if (first0[2]) begin
                s_ptr <= first0[1:0];
                i_ptr <= 4'd0;
                state <= S_CRD;
              end else begin
                sum      <= '0;
                qual     <= 1'b0;
                tgt      <= TGT_NONE;
                stopped  <= 1'b0;
                len      <= '{default: 4'd0};
                state    <= S_IN;
              end
            end else begin
              rec_idx <= rec_idx + 3'd1;
            end
          end
        end
        S_CRD: state <= S_CWT;
        S_CWT: begin
          if (out_free) begin
            out_kind  <= KIND_NAME + 4'(s_ptr);
            out_slot  <= i_ptr;
            out_value <= {32'd0, rd_data};
            out_last  <= !(i_ptr + 4'd1 < len[s_ptr]) && !after_cur[2];
            if (i_ptr + 4'd1 < len[s_ptr]) begin
              i_ptr <= i_ptr + 4'd1;
              state <= S_CRD;
            end else if (after_cur[2]) begin
              s_ptr <= after_cur[1:0];
              i_ptr <= 4'd0;
              state <= S_CRD;
            end else begin
              sum      <= '0;
              qual     <= 1'b0;
              tgt      <= TGT_NONE;
              stopped  <= 1'b0;
              len      <= '{default: 4'd0};
              state    <= S_IN;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  assign rec_out.valid        = out_valid;
  assign rec_out.record_kind  = out_kind;
  assign rec_out.char_slot    = out_slot;
  assign rec_out.record_value = out_value;
  assign rec_out.is_last      = out_last;

  `EBX_ASSERT_NXT(a_last_starts_emit, clk, rst, accept && pos == 7'(LastPos), state == S_REC, "byte 127 did not start emission")
  `EBX_ASSERT_IMP(a_len_range, clk, rst, 1'b1, len[0] <= 4'(TextChars) && len[1] <= 4'(TextChars) && len[2] <= 4'(TextChars), "string length out of range")
  `EBX_ASSERT_IMP(a_trim_has_target, clk, rst, state == S_TRIM || state == S_TWAIT, tgt != TGT_NONE, "trim without a target string")
  `EBX_ASSERT_IMP(a_char_nonempty, clk, rst, state == S_CWT, i_ptr < len[s_ptr], "character read beyond string length")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import edid_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic [39:0] value;
    logic        last;
  } edid_rec_t;

  logic clk;
  logic rst;

  edid_in_if  in_bus ();
  edid_out_if out_bus ();

  edid_base_block_field_extractor u_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (in_bus),
    .rec_out (out_bus)
  );

  logic [7:0] pending_bytes[$];
  edid_rec_t  expected_recs[$];
  int         error_count = 0;
  int         cycle_count = 0;

  // shadow of the parser state
  logic [6:0] sh_pos;
  logic [7:0] sh_sum;
  logic [7:0] sh_hdr[HdrBytes];
  logic [7:0] sh_ext;
  logic       sh_qual;
  logic [1:0] sh_tgt;
  logic       sh_stopped;
  logic [7:0] sh_store[StoreDepth];
  logic [3:0] sh_len[3];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [9:0] chroma(input logic [7:0] hi, input logic [1:0] lo);
    return {hi, lo};
  endfunction

  task automatic clear_text_state();
    sh_sum = '0;
    sh_qual = 1'b0;
    sh_tgt = TGT_NONE;
    sh_stopped = 1'b0;
    for (int i = 0; i < 3; i++) sh_len[i] = '0;
  endtask

  task automatic reset_shadow();
    sh_pos = '0;
    sh_ext = '0;
    for (int i = 0; i < HdrBytes; i++) sh_hdr[i] = '0;
    for (int i = 0; i < StoreDepth; i++) sh_store[i] = '0;
    clear_text_state();
  endtask

  task automatic track_descriptor(input int p, input logic [7:0] b);
    int rel, d, off, idx, base, n;
    if (p < DescStart) return;
    rel = p - DescStart;
    d = rel / DescSize;
    off = rel % DescSize;
    if (d >= DescCount) return;
    if (off == 0) begin
      sh_qual = (b == 8'h00);
      sh_tgt = TGT_NONE;
      sh_stopped = 1'b0;
    end else if (off == 1 || off == 2) begin
      sh_qual = sh_qual && (b == 8'h00);
    end else if (off == 3) begin
      sh_tgt = (b == TAG_NAME) ? TGT_NAME : (b == TAG_SER) ? TGT_SER :
               (b == TAG_OTHER) ? TGT_OTHER : TGT_NONE;
    end else if (off == 4) begin
      if (sh_qual && b == 8'h00 && sh_tgt != TGT_NONE) begin
        sh_len[sh_tgt - 1] = '0;
        sh_stopped = 1'b0;
      end else begin
        sh_tgt = TGT_NONE;
      end
    end else if (sh_tgt != TGT_NONE) begin
      idx = off - 5;
      base = (sh_tgt - 1) * DescData;
      if (!sh_stopped && idx < TextChars) begin
        if (b == CHAR_LF || b == 8'h00) sh_stopped = 1'b1;
        else begin
          sh_store[base + idx] = b;
          sh_len[sh_tgt - 1] = 4'(idx + 1);
        end
      end
      if (off == DescSize - 1) begin
        n = sh_len[sh_tgt - 1];
        while (n > 0 && blank_char(sh_store[base + n - 1])) n--;
        sh_len[sh_tgt - 1] = 4'(n);
        sh_tgt = TGT_NONE;
      end
    end
  endtask

  task automatic push_rec(input logic [3:0] k, input logic [3:0] s, input logic [39:0] v);
    edid_rec_t r;
    r.kind = k;
    r.slot = s;
    r.value = v;
    r.last = 1'b0;
    expected_recs.push_back(r);
  endtask

  // advance the shadow by one byte; on the last offset queue the block's records
  task automatic parse_byte(input logic [7:0] b);
    int p;
    logic [7:0] h[HdrBytes];
    logic [7:0] l0, l1, l2;
    edid_rec_t r;
    p = sh_pos;
    sh_sum = sh_sum + b;
    if (p >= HdrFirst && p < HdrFirst + HdrBytes) sh_hdr[p - HdrFirst] = b;
    if (p == ExtPos) sh_ext = b;
    track_descriptor(p, b);
    sh_pos = sh_pos + 7'd1;
    if (p != LastPos) return;
    h = sh_hdr;
    // offsets below are relative to byte 8
    l0 = {3'b0, h[0][6:2]} + 8'd64;
    l1 = {3'b0, h[0][1:0], h[1][7:5]} + 8'd64;
    l2 = {3'b0, h[1][4:0]} + 8'd64;
    push_rec(KIND_ID, 4'd0, {l0, l1, l2, h[3], h[2]});
    push_rec(KIND_SERIAL, 4'd0, {8'd0, h[7], h[6], h[5], h[4]});
    push_rec(KIND_DATES, 4'd0, {12'(h[9] + YearBase), h[8] == WEEK_MY, 3'd0, h[8],
                                h[10], h[11]});
    push_rec(KIND_MISC, 4'd0, {h[12], h[16], sh_ext, 3'd0, sh_sum == 8'h00,
                               sh_len[0], sh_len[1], sh_len[2]});
    push_rec(KIND_RG, 4'd0, {chroma(h[19], h[17][7:6]), chroma(h[20], h[17][5:4]),
                             chroma(h[21], h[17][3:2]), chroma(h[22], h[17][1:0])});
    push_rec(KIND_BW, 4'd0, {chroma(h[23], h[18][7:6]), chroma(h[24], h[18][5:4]),
                             chroma(h[25], h[18][3:2]), chroma(h[26], h[18][1:0])});
    for (int s = 0; s < 3; s++)
      for (int i = 0; i < sh_len[s]; i++)
        push_rec(KIND_NAME + 4'(s), 4'(i), {32'd0, sh_store[s * DescData + i]});
    r = expected_recs.pop_back();
    r.last = 1'b1;
    expected_recs.push_back(r);
    clear_text_state();
  endtask

  // ---------------- stimulus building ----------------
  logic [7:0] blk[128];

  task automatic put_text(input int d, input logic [7:0] tag, input string txt,
                          input logic [7:0] pad);
    int base;
    base = DescStart + d * DescSize;
    blk[base] = 8'h00;
    blk[base + 1] = 8'h00;
    blk[base + 2] = 8'h00;
    blk[base + 3] = tag;
    blk[base + 4] = 8'h00;
    for (int i = 0; i < DescData; i++)
      blk[base + 5 + i] = (i < txt.len()) ? txt[i] : pad;
  endtask

  task automatic queue_block(input bit fix_sum);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < 127; i++) s = s + blk[i];
    if (fix_sum) blk[127] = 8'h00 - s;
    for (int i = 0; i < 128; i++) pending_bytes.push_back(blk[i]);
  endtask

  // ---------------- driver ----------------
  int send_gap;

  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      in_bus.byte_value <= '0;
      send_gap <= 0;
      reset_shadow();
    end else begin
      if (in_bus.valid && in_bus.ready) parse_byte(in_bus.byte_value);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_bus.byte_value <= pending_bytes.pop_front();
          in_bus.valid <= 1'b1;
          if (cycle_count[11]) send_gap <= 0;
          else case ($urandom_range(0, 19))
            0: send_gap <= $urandom_range(10, 40);
            1, 2, 3, 4, 5: send_gap <= $urandom_range(1, 3);
            default: send_gap <= 0;
          endcase
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int   recv_stall;
  logic long_done;

  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      recv_stall <= 0;
      long_done <= 1'b0;
    end else if (!long_done && out_bus.valid) begin
      // long back-pressure on the first record while the sender keeps going
      out_bus.ready <= 1'b0;
      recv_stall <= 300;
      long_done <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (!cycle_count[10])
        case ($urandom_range(0, 19))
          0: recv_stall <= $urandom_range(10, 50);
          1, 2, 3, 4, 5, 6: recv_stall <= $urandom_range(1, 3);
          default: recv_stall <= 0;
        endcase
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    edid_rec_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_recs.size() == 0) begin
        report($sformatf("unexpected record kind %0d", out_bus.record_kind));
      end else begin
        want = expected_recs.pop_front();
        if (out_bus.record_kind !== want.kind)
          report($sformatf("kind %0d, want %0d", out_bus.record_kind, want.kind));
        if (out_bus.char_slot !== want.slot)
          report($sformatf("kind %0d slot %0d, want %0d", want.kind, out_bus.char_slot,
                           want.slot));
        if (out_bus.record_value !== want.value)
          report($sformatf("kind %0d slot %0d value %h, want %h", want.kind, want.slot,
                           out_bus.record_value, want.value));
        if (out_bus.is_last !== want.last)
          report($sformatf("kind %0d is_last %b, want %b", want.kind, out_bus.is_last,
                           want.last));
      end
    end
  end

  initial begin
    // directed: text stops, trailing blanks, repeated tag, model-year week
    for (int i = 0; i < 128; i++) blk[i] = 8'(i * 7 + 3);
    blk[16] = WEEK_MY;
    put_text(0, TAG_NAME, "AB\n", 8'h20);
    put_text(1, TAG_SER, "0123456789ABC", 8'h20);
    put_text(2, TAG_OTHER, "x y", 8'h0d);
    put_text(3, TAG_NAME, "MON", 8'h00);
    queue_block(1'b1);
    // start of the next block, offered while the records are held off
    for (int i = 0; i < 2; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));

    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_bus.valid) @(posedge clk);
    while (expected_recs.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_recs.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/edid_pkg.sv
design/edid_in_if.sv
design/edid_out_if.sv
design/edid_base_block_field_extractor.sv
tb/testbench.sv
